// File: design/rfbm_pkg.sv
// Package for the redundant frame block merger.
// Holds sizes, action codes, the controller state type and the command and status structs; no dependencies.
package rfbm_pkg;
   localparam int MaxSources = 8;
   localparam int MaxBlocks = 2048;
   localparam int SrcW = $clog2(MaxSources);
   localparam int BlkW = $clog2(MaxBlocks);
   localparam int CntW = BlkW + 1;
   localparam int StoreDepth = MaxSources * MaxBlocks;
   localparam int StoreAw = SrcW + BlkW;
   localparam int PickW = SrcW + 2;

   typedef enum logic [1:0] {
      ACT_HEADER  = 2'd0,
      ACT_STATUS  = 2'd1,
      ACT_PROCESS = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COUNT_RD,
      ST_COUNT_WAIT,
      ST_COUNT_ACC,
      ST_SORT,
      ST_MERGE_RD,
      ST_MERGE_WAIT,
      ST_MERGE_EVAL,
      ST_FILL,
      ST_QUERY_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic clear_cnt;
      logic count_acc;
      logic sort_step;
      logic merge_eval;
      logic fill_write;
      logic out_load;
      logic query_rd;
      logic query_load;
   } cmd_type;

   typedef struct packed {
      logic has_pref;
      logic any_usable;
      logic count_last;
      logic sort_done;
      logic merge_done;
      logic blk_last;
      logic zero_blocks;
   } status_type;
endpackage

// File: design/rfbm_ram.sv
// Generic single-port write, single-port registered read RAM.
// No dependencies.
module rfbm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/rfbm_datapath.sv
// Datapath of the merger: source flags, bad-block counters, ranking, stores.
// Depends on rfbm_pkg and rfbm_ram; driven by rfbm_ctrl through commands.
module rfbm_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [3:0]                csr_data,
   input  logic                      load_header,
   input  logic                      load_status,
   input  logic [2:0]                req_source,
   input  logic                      req_frame_missing,
   input  logic                      req_block_issue,
   input  logic                      req_tc_issue,
   input  logic [10:0]               req_block_index,
   input  logic [7:0]                req_block_status,
   input  logic [11:0]               req_block_count,
   input  rfbm_pkg::cmd_type         cmd,
   output rfbm_pkg::status_type      sts,
   output logic [1:0]                frame_class,
   output logic [3:0]                chosen_source,
   output logic [3:0]                tc_source,
   output logic [11:0]               error_blocks,
   output logic [3:0]                block_source,
   output logic                      block_bad
);
   localparam int SW = rfbm_pkg::SrcW;
   localparam int BW = rfbm_pkg::BlkW;
   localparam int CW = rfbm_pkg::CntW;
   localparam int NS = rfbm_pkg::MaxSources;
   localparam int KW = CW + 1;

   logic [3:0] nsrc_ff;
   logic [2:0] flags_ff [NS];
   logic [CW-1:0] badcnt_ff [NS];
   logic [SW-1:0] rank_ff [NS];
   logic [CW-1:0] fcount_ff;
   logic [CW-1:0] blk_ff;
   logic [SW:0] si_ff;
   logic [SW:0] pref_ff;
   logic [SW:0] tcs_ff;
   logic any_ff;
   logic [SW:0] sort_i_ff;
   logic [SW:0] sort_k_ff;
   logic [CW-1:0] err_ff;
   logic [1:0] cls_ff;
   logic qvalid_ff;

   logic [SW:0] n_eff;
   logic [CW-1:0] cnt_sat;
   logic [rfbm_pkg::StoreAw-1:0] st_waddr;
   logic [1:0] st_wdata, st_rdata;
   logic st_we;
   logic [BW-1:0] blk_idx;
   logic pk_we;
   logic [rfbm_pkg::PickW-1:0] pk_wdata, pk_rdata;
   logic [BW-1:0] pk_waddr, pk_raddr;
   logic [SW:0] pref_c, tcs_c;
   logic any_c;
   logic [KW-1:0] key_a, key_b;
   logic swap;
   logic usable_k;

   function automatic logic usable_f(input logic [2:0] f);
      return f[1:0] == 2'b10;
   endfunction

   always_comb begin
      if (nsrc_ff == 4'd0) begin
         n_eff = (SW+1)'(1);
      end else if (nsrc_ff > 4'(NS)) begin
         n_eff = (SW+1)'(NS);
      end else begin
         n_eff = (SW+1)'(nsrc_ff);
      end
      cnt_sat = (req_block_count > 12'(rfbm_pkg::MaxBlocks)) ?
                CW'(rfbm_pkg::MaxBlocks) : CW'(req_block_count);
   end

   always_comb begin
      pref_c = (SW+1)'(NS);
      tcs_c = (SW+1)'(NS);
      any_c = 1'b0;
      for (int i = NS - 1; i >= 0; i--) begin
         if ((SW+1)'(i) < n_eff) begin
            if (flags_ff[i][1:0] == 2'b00) pref_c = (SW+1)'(i);
            if (!flags_ff[i][2]) tcs_c = (SW+1)'(i);
            if (usable_f(flags_ff[i])) any_c = 1'b1;
         end
      end
   end

   assign blk_idx = blk_ff[BW-1:0];
   assign usable_k = usable_f(flags_ff[rank_ff[si_ff[SW-1:0]]]);
   assign st_we = load_status;
   assign st_waddr = {req_source, req_block_index};
   assign st_wdata = (req_block_status == 8'd1 || req_block_status == 8'd2) ?
                     req_block_status[1:0] : 2'd0;

   // Read address: counting walks source then block; merging walks ranked sources.
   logic merging_ff;
   logic [rfbm_pkg::StoreAw-1:0] raddr;
   assign raddr = merging_ff ? {rank_ff[si_ff[SW-1:0]], blk_idx}
                             : {si_ff[SW-1:0], blk_idx};

   rfbm_ram #(.Width(2), .Depth(rfbm_pkg::StoreDepth)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(raddr), .rd_data(st_rdata)
   );

   assign pk_raddr = req_block_index;
   assign pk_waddr = blk_idx;

   rfbm_ram #(.Width(rfbm_pkg::PickW), .Depth(rfbm_pkg::MaxBlocks)) u_pick (
      .clock(clock), .wr_en(pk_we), .wr_addr(pk_waddr), .wr_data(pk_wdata),
      .rd_addr(pk_raddr), .rd_data(pk_rdata)
   );

   // Merge decision for the current ranked source.
   logic m_stop, m_bad_end, m_last_k;
   logic [SW-1:0] m_src;
   always_comb begin
      m_last_k = (si_ff + 1'b1) >= n_eff;
      m_stop = 1'b0;
      m_bad_end = 1'b0;
      m_src = rank_ff[0];
      if (!usable_k) begin
         m_stop = 1'b1;
         m_bad_end = 1'b1;
      end else if (st_rdata == 2'd2) begin
         m_stop = m_last_k;
         m_bad_end = m_last_k;
      end else begin
         m_stop = 1'b1;
         if (st_rdata == 2'd1) m_src = rank_ff[si_ff[SW-1:0]];
      end
   end

   always_comb begin
      pk_we = 1'b0;
      pk_wdata = '0;
      if (cmd.fill_write) begin
         pk_we = 1'b1;
         pk_wdata = pref_ff != (SW+1)'(NS) ? {1'b0, pref_ff} : {1'b1, (SW+1)'(NS)};
      end else if (cmd.merge_eval && m_stop) begin
         pk_we = 1'b1;
         pk_wdata = {m_bad_end, 1'b0, m_src};
      end
   end

   // Insertion sort, one compare per cycle.
   always_comb begin
      key_a = usable_f(flags_ff[rank_ff[sort_k_ff[SW-1:0] - 1'b1]]) ?
              KW'(badcnt_ff[rank_ff[sort_k_ff[SW-1:0] - 1'b1]]) : {1'b1, {CW{1'b0}}};
      key_b = usable_f(flags_ff[rank_ff[sort_k_ff[SW-1:0]]]) ?
              KW'(badcnt_ff[rank_ff[sort_k_ff[SW-1:0]]]) : {1'b1, {CW{1'b0}}};
      swap = sort_k_ff != '0 && key_a > key_b;
   end

   assign sts.has_pref = pref_ff != (SW+1)'(NS);
   assign sts.any_usable = any_ff;
   assign sts.count_last = (blk_ff + 1'b1 >= fcount_ff) && (si_ff + 1'b1 >= n_eff);
   assign sts.sort_done = sort_i_ff >= n_eff;
   assign sts.merge_done = m_stop;
   assign sts.blk_last = blk_ff + 1'b1 >= fcount_ff;
   assign sts.zero_blocks = fcount_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         nsrc_ff <= 4'd2;
         fcount_ff <= '0;
         for (int i = 0; i < NS; i++) begin
            flags_ff[i] <= '0;
            badcnt_ff[i] <= '0;
            rank_ff[i] <= SW'(i);
         end
         merging_ff <= 1'b0;
      end else begin
         if (csr_write) nsrc_ff <= csr_data;
         if (load_header) begin
            flags_ff[req_source] <= {req_tc_issue, req_block_issue, req_frame_missing};
         end
         if (cmd.start) begin
            fcount_ff <= cnt_sat;
            pref_ff <= pref_c;
            tcs_ff <= tcs_c;
            any_ff <= any_c;
            blk_ff <= '0;
            si_ff <= '0;
            err_ff <= '0;
            merging_ff <= 1'b0;
            for (int i = 0; i < NS; i++) rank_ff[i] <= SW'(i);
            sort_i_ff <= (SW+1)'(1);
            sort_k_ff <= (SW+1)'(1);
         end
         if (cmd.clear_cnt) begin
            for (int i = 0; i < NS; i++) badcnt_ff[i] <= '0;
         end
         if (cmd.count_acc) begin
            if (usable_f(flags_ff[si_ff[SW-1:0]]) && st_rdata == 2'd2 &&
                blk_ff < fcount_ff) begin
               badcnt_ff[si_ff[SW-1:0]] <= badcnt_ff[si_ff[SW-1:0]] + 1'b1;
            end
            if (blk_ff + 1'b1 >= fcount_ff) begin
               blk_ff <= '0;
               si_ff <= si_ff + 1'b1;
            end else begin
               blk_ff <= blk_ff + 1'b1;
            end
         end
         if (cmd.sort_step) begin
            if (!sts.sort_done) begin
               if (swap) begin
                  rank_ff[sort_k_ff[SW-1:0]] <= rank_ff[sort_k_ff[SW-1:0] - 1'b1];
                  rank_ff[sort_k_ff[SW-1:0] - 1'b1] <= rank_ff[sort_k_ff[SW-1:0]];
                  sort_k_ff <= sort_k_ff - 1'b1;
               end else begin
                  sort_i_ff <= sort_i_ff + 1'b1;
                  sort_k_ff <= sort_i_ff + 1'b1;
               end
            end
            blk_ff <= '0;
            si_ff <= '0;
            merging_ff <= 1'b1;
         end
         if (cmd.merge_eval) begin
            if (m_stop) begin
               si_ff <= '0;
               blk_ff <= blk_ff + 1'b1;
               if (m_bad_end) err_ff <= err_ff + 1'b1;
            end else begin
               si_ff <= si_ff + 1'b1;
            end
         end
         if (cmd.fill_write) blk_ff <= blk_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (pref_ff != (SW+1)'(NS)) begin
            cls_ff <= 2'd0;
            chosen_source <= 4'(pref_ff);
            error_blocks <= 12'd0;
         end else if (!any_ff) begin
            cls_ff <= 2'd3;
            chosen_source <= 4'(NS);
            error_blocks <= 12'(fcount_ff);
         end else begin
            cls_ff <= (err_ff != '0) ? 2'd2 : 2'd1;
            chosen_source <= 4'(rank_ff[0]);
            error_blocks <= 12'(err_ff);
         end
         tc_source <= 4'(tcs_ff);
         block_source <= 4'd0;
         block_bad <= 1'b0;
      end
      if (cmd.query_rd) begin
         qvalid_ff <= CW'(req_block_index) < fcount_ff;
      end
      if (cmd.query_load) begin
         cls_ff <= 2'd0;
         chosen_source <= 4'd0;
         tc_source <= 4'd0;
         error_blocks <= 12'd0;
         if (qvalid_ff) begin
            block_source <= 4'(pk_rdata[SW:0]);
            block_bad <= pk_rdata[SW+1];
         end else begin
            block_source <= 4'(NS);
            block_bad <= 1'b0;
         end
      end
   end

   assign frame_class = cls_ff;
endmodule

// File: design/rfbm_ctrl.sv
// Controller state machine of the merger.
// Depends on rfbm_pkg; commands rfbm_datapath and runs the handshakes.
module rfbm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_kind,
   output logic                  load_header,
   output logic                  load_status,
   output rfbm_pkg::cmd_type     cmd,
   input  rfbm_pkg::status_type  sts
);
   rfbm_pkg::state_type state_ff, state_in;
   logic valid_ff, valid_in, kind_ff, kind_in;
   logic accept;
   rfbm_pkg::action_type act;

   assign act = rfbm_pkg::action_type'(req_action);
   assign req_stall = state_ff != rfbm_pkg::ST_IDLE || valid_ff;
   assign accept = req_valid && !req_stall;
   assign load_header = accept && act == rfbm_pkg::ACT_HEADER;
   assign load_status = accept && act == rfbm_pkg::ACT_STATUS;
   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfbm_pkg::ST_IDLE: begin
            if (accept && act == rfbm_pkg::ACT_PROCESS) state_in = rfbm_pkg::ST_SCAN;
            else if (accept && act == rfbm_pkg::ACT_QUERY)
               state_in = rfbm_pkg::ST_QUERY_WAIT;
         end
         rfbm_pkg::ST_SCAN: begin
            if (sts.has_pref) state_in = sts.zero_blocks ? rfbm_pkg::ST_OUT : rfbm_pkg::ST_FILL;
            else if (!sts.any_usable)
               state_in = sts.zero_blocks ? rfbm_pkg::ST_OUT : rfbm_pkg::ST_FILL;
            else if (sts.zero_blocks) state_in = rfbm_pkg::ST_SORT;
            else state_in = rfbm_pkg::ST_COUNT_RD;
         end
         rfbm_pkg::ST_COUNT_RD: state_in = rfbm_pkg::ST_COUNT_WAIT;
         rfbm_pkg::ST_COUNT_WAIT: state_in = rfbm_pkg::ST_COUNT_ACC;
         rfbm_pkg::ST_COUNT_ACC:
            state_in = sts.count_last ? rfbm_pkg::ST_SORT : rfbm_pkg::ST_COUNT_RD;
         rfbm_pkg::ST_SORT: begin
            if (sts.sort_done)
               state_in = sts.zero_blocks ? rfbm_pkg::ST_OUT : rfbm_pkg::ST_MERGE_RD;
         end
         rfbm_pkg::ST_MERGE_RD: state_in = rfbm_pkg::ST_MERGE_WAIT;
         rfbm_pkg::ST_MERGE_WAIT: state_in = rfbm_pkg::ST_MERGE_EVAL;
         rfbm_pkg::ST_MERGE_EVAL: begin
            if (sts.merge_done && sts.blk_last) state_in = rfbm_pkg::ST_OUT;
            else state_in = rfbm_pkg::ST_MERGE_RD;
         end
         rfbm_pkg::ST_FILL: if (sts.blk_last) state_in = rfbm_pkg::ST_OUT;
         rfbm_pkg::ST_QUERY_WAIT: state_in = rfbm_pkg::ST_IDLE;
         rfbm_pkg::ST_OUT: state_in = rfbm_pkg::ST_IDLE;
         default: state_in = rfbm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      valid_in = valid_ff && rsp_stall;
      kind_in = kind_ff;
      case (state_ff)
         rfbm_pkg::ST_IDLE: begin
            if (accept && act == rfbm_pkg::ACT_PROCESS) cmd.start = 1'b1;
            if (accept && act == rfbm_pkg::ACT_QUERY) cmd.query_rd = 1'b1;
         end
         rfbm_pkg::ST_SCAN: cmd.clear_cnt = !sts.has_pref;
         rfbm_pkg::ST_COUNT_ACC: cmd.count_acc = 1'b1;
         rfbm_pkg::ST_SORT: cmd.sort_step = 1'b1;
         rfbm_pkg::ST_MERGE_EVAL: cmd.merge_eval = 1'b1;
         rfbm_pkg::ST_FILL: cmd.fill_write = 1'b1;
         rfbm_pkg::ST_QUERY_WAIT: begin
            cmd.query_load = 1'b1;
            valid_in = 1'b1;
            kind_in = 1'b1;
         end
         rfbm_pkg::ST_OUT: begin
            cmd.out_load = 1'b1;
            valid_in = 1'b1;
            kind_in = 1'b0;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfbm_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         kind_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         kind_ff <= kind_in;
      end
   end
endmodule

// File: design/redundant_frame_block_merger.sv
// Redundant frame block merger. A process word walks the status memory, one
// 2-bit read per source and block while counting bad blocks (read, wait and
// accumulate states per read), then sorts sources one compare a cycle, then
// merges, reading ranked sources in turn for each block. Every read uses the
// single read port of the 16K-entry status memory. A result word is held
// until it is taken.
// Top level; depends on rfbm_pkg, rfbm_ctrl, rfbm_datapath and rfbm_ram.
module redundant_frame_block_merger (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [3:0]  csr_num_sources,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_source,
   input  logic        req_frame_missing,
   input  logic        req_block_issue,
   input  logic        req_tc_issue,
   input  logic [10:0] req_block_index,
   input  logic [7:0]  req_block_status,
   input  logic [11:0] req_block_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_frame_class,
   output logic [3:0]  rsp_chosen_source,
   output logic [3:0]  rsp_tc_source,
   output logic [11:0] rsp_error_blocks,
   output logic [3:0]  rsp_block_source,
   output logic        rsp_block_bad
);
   rfbm_pkg::cmd_type cmd;
   rfbm_pkg::status_type sts;
   logic load_header, load_status;

   rfbm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_action(req_action),
      .req_stall(req_stall), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_result_kind), .load_header(load_header),
      .load_status(load_status), .cmd(cmd), .sts(sts)
   );

   rfbm_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_num_sources),
      .load_header(load_header), .load_status(load_status), .req_source(req_source),
      .req_frame_missing(req_frame_missing), .req_block_issue(req_block_issue),
      .req_tc_issue(req_tc_issue), .req_block_index(req_block_index),
      .req_block_status(req_block_status), .req_block_count(req_block_count),
      .cmd(cmd), .sts(sts), .frame_class(rsp_frame_class),
      .chosen_source(rsp_chosen_source), .tc_source(rsp_tc_source),
      .error_blocks(rsp_error_blocks), .block_source(rsp_block_source),
      .block_bad(rsp_block_bad)
   );
endmodule
